// File: src/lmgr_pkg.sv
// shared constants, types and font rom for the led matrix glyph rasterizer
package lmgr_pkg;

   localparam int MAX_DIM      = 128;
   localparam int DIM_W        = 8;
   localparam int COORD_W      = $clog2(MAX_DIM);
   localparam int INDEX_W      = 14;
   localparam int COLOR_W      = 24;
   localparam int CODE_W       = 8;
   localparam int GLYPH_ROWS   = 5;
   localparam int GLYPH_COLS   = 3;
   localparam int GLYPH_PIXELS = GLYPH_ROWS * GLYPH_COLS;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 8;
   localparam int REQ_W        = 48;
   localparam int RSP_W        = 40;
   localparam int RSP_PAD      = RSP_W - INDEX_W - COLOR_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIRROR   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOTTOM   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZIGZAG   = 3'd5;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 8'd32;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 8'd8;

   typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_type;

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [1:0]       rot;
      logic             mirror;
      logic             bottom;
      logic             zigzag;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } pixel_type;

   function automatic glyph_type glyph_of(input logic [2:0] r0, input logic [2:0] r1,
                                          input logic [2:0] r2, input logic [2:0] r3,
                                          input logic [2:0] r4);
      glyph_type g;
      g = {r4, r3, r2, r1, r0};
      return g;
   endfunction

   // row r in g[r], bit 2 is the left column
   function automatic glyph_type glyph_rows(input logic [CODE_W-1:0] code);
      glyph_type g;
      case (code)
         8'h30: g = glyph_of(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
         8'h31: g = glyph_of(3'd2, 3'd6, 3'd2, 3'd2, 3'd7);
         8'h32: g = glyph_of(3'd7, 3'd1, 3'd7, 3'd4, 3'd7);
         8'h33: g = glyph_of(3'd7, 3'd1, 3'd7, 3'd1, 3'd7);
         8'h34: g = glyph_of(3'd5, 3'd5, 3'd7, 3'd1, 3'd1);
         8'h35: g = glyph_of(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
         8'h36: g = glyph_of(3'd7, 3'd4, 3'd7, 3'd5, 3'd7);
         8'h37: g = glyph_of(3'd7, 3'd1, 3'd2, 3'd2, 3'd2);
         8'h38: g = glyph_of(3'd7, 3'd5, 3'd7, 3'd5, 3'd7);
         8'h39: g = glyph_of(3'd7, 3'd5, 3'd7, 3'd1, 3'd7);
         8'h2D: g = glyph_of(3'd0, 3'd0, 3'd7, 3'd0, 3'd0);
         8'h2E: g = glyph_of(3'd0, 3'd0, 3'd0, 3'd0, 3'd2);
         8'h3A: g = glyph_of(3'd0, 3'd2, 3'd0, 3'd2, 3'd0);
         8'h41: g = glyph_of(3'd7, 3'd5, 3'd7, 3'd5, 3'd5);
         8'h42: g = glyph_of(3'd6, 3'd5, 3'd6, 3'd5, 3'd6);
         8'h43: g = glyph_of(3'd7, 3'd4, 3'd4, 3'd4, 3'd7);
         8'h44: g = glyph_of(3'd6, 3'd5, 3'd5, 3'd5, 3'd6);
         8'h45: g = glyph_of(3'd7, 3'd4, 3'd6, 3'd4, 3'd7);
         8'h46: g = glyph_of(3'd7, 3'd4, 3'd6, 3'd4, 3'd4);
         8'h48: g = glyph_of(3'd5, 3'd5, 3'd7, 3'd5, 3'd5);
         8'h49: g = glyph_of(3'd7, 3'd2, 3'd2, 3'd2, 3'd7);
         8'h4C: g = glyph_of(3'd4, 3'd4, 3'd4, 3'd4, 3'd7);
         8'h4D: g = glyph_of(3'd5, 3'd7, 3'd5, 3'd5, 3'd5);
         8'h4E: g = glyph_of(3'd5, 3'd7, 3'd7, 3'd7, 3'd5);
         8'h4F: g = glyph_of(3'd7, 3'd5, 3'd5, 3'd5, 3'd7);
         8'h52: g = glyph_of(3'd6, 3'd5, 3'd6, 3'd5, 3'd5);
         8'h53: g = glyph_of(3'd7, 3'd4, 3'd7, 3'd1, 3'd7);
         8'h54: g = glyph_of(3'd7, 3'd2, 3'd2, 3'd2, 3'd2);
         8'h55: g = glyph_of(3'd5, 3'd5, 3'd5, 3'd5, 3'd7);
         8'h56: g = glyph_of(3'd5, 3'd5, 3'd5, 3'd5, 3'd2);
         8'h57: g = glyph_of(3'd5, 3'd5, 3'd5, 3'd7, 3'd5);
         8'h59: g = glyph_of(3'd5, 3'd5, 3'd2, 3'd2, 3'd2);
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// File: src/led_matrix_glyph_rasterizer.sv
// top level: 3x5 font glyph rasterizer for a serpentine led matrix
//
// req channel: one beat per character (origin, code, color). rsp channel: one
// beat per lit pixel that lands on the matrix, carrying the strip index and
// the color; tlast marks the final beat of a character. characters that are
// unknown, blank or fully clipped produce no beats at all.
// csr port: a write at any edge with csr_wen high; change it only while idle.
// path: the first rsp beat of a character follows its req beat through the
// input register, font lookup and clip, then three pixel stages.
// throughput: one led write per cycle while rsp_tready stays high. the pixel
// serializer holds a character until its n visible pixels (at most 15) have
// left, and the next req beat is taken as the last pixel leaves it; the index
// stage uses one 7x8 multiplier.
// reset: registers return to 32x8, no rotation, no mirror, top start, no
// zigzag; all pipeline stages are emptied.
// stall: a low rsp_tready holds the stages up to the first gap and, once the
// serializer and input register fill, drops req_tready; nothing is lost or repeated.
module led_matrix_glyph_rasterizer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // origin_x, origin_y, char_code, ink_color
   input  logic [lmgr_pkg::REQ_W-1:0]       req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // led_index, led_color, zero fill
   output logic [lmgr_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_wen,
   input  logic [lmgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lmgr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lmgr_pkg::*;

   logic [DIM_W-1:0] width_ff, height_ff;
   logic [1:0]       rotation_ff;
   logic             mirror_ff, bottom_ff, zigzag_ff;
   cfg_type          cfg;

   logic               s1_valid_ff;
   logic [DIM_W-1:0]   s1_ox_ff, s1_oy_ff;
   logic [CODE_W-1:0]  s1_code_ff;
   logic [COLOR_W-1:0] s1_color_ff;
   logic               s1_ready;

   logic                    s2_valid_ff, s2_valid_in;
   logic [GLYPH_PIXELS-1:0] s2_mask_ff, s2_mask_in;
   logic [DIM_W-1:0]        s2_ox_ff, s2_oy_ff;
   logic [COLOR_W-1:0]      s2_color_ff;

   glyph_type               glyph;
   logic [GLYPH_PIXELS-1:0] load_mask;
   logic [GLYPH_PIXELS-1:0] pick_onehot, rest_mask;
   logic [2:0]              pick_row;
   logic [1:0]              pick_col;
   logic                    s2_emit, s2_free, s2_load;
   logic                    pm_ready;
   pixel_type               pix;
   logic [INDEX_W-1:0]      rsp_index;
   logic [COLOR_W-1:0]      rsp_color;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         rotation_ff <= ROT_0;
         mirror_ff   <= 1'b0;
         bottom_ff   <= 1'b0;
         zigzag_ff   <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_WIDTH:    width_ff    <= csr_wdata;
            CSR_HEIGHT:   height_ff   <= csr_wdata;
            CSR_ROTATION: rotation_ff <= csr_wdata[1:0];
            CSR_MIRROR:   mirror_ff   <= csr_wdata[0];
            CSR_BOTTOM:   bottom_ff   <= csr_wdata[0];
            CSR_ZIGZAG:   zigzag_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.w      = (width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_ff;
      cfg.h      = (height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_ff;
      cfg.rot    = rotation_ff;
      cfg.mirror = mirror_ff;
      cfg.bottom = bottom_ff;
      cfg.zigzag = zigzag_ff;
   end

   // input register
   assign s1_ready   = !s1_valid_ff || s2_free;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (s1_ready) s1_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ox_ff    <= req_tdata[7:0];
         s1_oy_ff    <= req_tdata[15:8];
         s1_code_ff  <= req_tdata[23:16];
         s1_color_ff <= req_tdata[47:24];
      end
   end

   // font lookup and per pixel clip
   always_comb begin
      logic [DIM_W:0] x9, y9, w9, h9;
      logic           keep;
      glyph = glyph_rows(s1_code_ff);
      w9    = {1'b0, cfg.w};
      h9    = {1'b0, cfg.h};
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         for (int c = 0; c < GLYPH_COLS; c++) begin
            x9   = {1'b0, s1_ox_ff} + (DIM_W+1)'(c);
            y9   = {1'b0, s1_oy_ff} + (DIM_W+1)'(r);
            keep = glyph[r][GLYPH_COLS-1-c] && (x9 < w9) && (y9 < h9);
            if (cfg.rot == ROT_90 &&
                !((y9 < w9) && ((w9 - (DIM_W+1)'(1) - x9) < h9))) keep = 1'b0;
            if (cfg.rot == ROT_270 &&
                !(((h9 - (DIM_W+1)'(1) - y9) < w9) && (x9 < h9))) keep = 1'b0;
            load_mask[r*GLYPH_COLS+c] = keep;
         end
      end
   end

   // pixel serializer, lowest row index then leftmost column first
   always_comb begin
      pick_row    = '0;
      pick_col    = '0;
      pick_onehot = '0;
      for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
         for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
            if (s2_mask_ff[r*GLYPH_COLS+c]) begin
               pick_row    = 3'(r);
               pick_col    = 2'(c);
               pick_onehot = GLYPH_PIXELS'(1) << (r*GLYPH_COLS+c);
            end
         end
      end
   end

   assign rest_mask = s2_mask_ff & ~pick_onehot;
   assign s2_emit   = s2_valid_ff && (s2_mask_ff != '0) && pm_ready;
   assign s2_free   = !s2_valid_ff || (s2_mask_ff == '0) || (s2_emit && rest_mask == '0);
   assign s2_load   = s1_valid_ff && s2_free;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_mask_in  = s2_mask_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
         s2_mask_in  = load_mask;
      end else if (s2_free) begin
         s2_valid_in = 1'b0;
      end else if (s2_emit) begin
         s2_mask_in  = rest_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else s2_valid_ff <= s2_valid_in;
   end

   always_ff @(posedge clock) begin
      s2_mask_ff <= s2_mask_in;
      if (s2_load) begin
         s2_ox_ff    <= s1_ox_ff;
         s2_oy_ff    <= s1_oy_ff;
         s2_color_ff <= s1_color_ff;
      end
   end

   always_comb begin
      pix.x     = COORD_W'(s2_ox_ff + DIM_W'(pick_col));
      pix.y     = COORD_W'(s2_oy_ff + DIM_W'(pick_row));
      pix.color = s2_color_ff;
      pix.last  = (rest_mask == '0);
   end

   lmgr_pixel_map u_pixel_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (s2_valid_ff && (s2_mask_ff != '0)),
      .in_ready  (pm_ready),
      .in_pix    (pix),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (rsp_index),
      .out_color (rsp_color),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_color, rsp_index};

   a_index_on_matrix: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_index} < ((INDEX_W+1)'(cfg.w) * (INDEX_W+1)'(cfg.h))))
      else $error("led index beyond matrix");

   a_one_pixel_per_emit: assert property (@(posedge clock) disable iff (reset)
      (s2_emit && !s2_free) |=>
         ($countones(s2_mask_ff) == $countones($past(s2_mask_ff)) - 1))
      else $error("serializer dropped or kept extra pixels");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!rsp_tvalid && !s2_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

// File: src/lmgr_pixel_map.sv
// three stage pixel pipeline: register, rotate and reflect, strip index
module lmgr_pixel_map (
   input  logic                        clock,
   input  logic                        reset,
   input  lmgr_pkg::cfg_type           cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  lmgr_pkg::pixel_type         in_pix,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [lmgr_pkg::INDEX_W-1:0] out_index,
   output logic [lmgr_pkg::COLOR_W-1:0] out_color,
   output logic                        out_last
);
   import lmgr_pkg::*;

   logic               a_valid_ff;
   pixel_type          a_pix_ff;
   logic               b_valid_ff;
   logic [COORD_W-1:0] b_row_ff, b_row_in;
   logic [COORD_W-1:0] b_col_ff, b_col_in;
   logic [COLOR_W-1:0] b_color_ff;
   logic               b_last_ff;
   logic               c_valid_ff;
   logic [INDEX_W-1:0] c_index_ff, c_index_in;
   logic [COLOR_W-1:0] c_color_ff;
   logic               c_last_ff;

   logic a_ready, b_ready, c_ready;
   logic [DIM_W-1:0] w1, h1, xe, ye, rot_c, rot_r, mir_c, bot_r, zig_c;

   assign c_ready  = !c_valid_ff || out_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      w1 = cfg.w - DIM_W'(1);
      h1 = cfg.h - DIM_W'(1);
      xe = DIM_W'(a_pix_ff.x);
      ye = DIM_W'(a_pix_ff.y);
      case (cfg.rot)
         ROT_90: begin
            rot_c = ye;
            rot_r = w1 - xe;
         end
         ROT_180: begin
            rot_c = w1 - xe;
            rot_r = h1 - ye;
         end
         ROT_270: begin
            rot_c = h1 - ye;
            rot_r = xe;
         end
         default: begin
            rot_c = xe;
            rot_r = ye;
         end
      endcase
      mir_c    = cfg.mirror ? w1 - rot_c : rot_c;
      bot_r    = cfg.bottom ? h1 - rot_r : rot_r;
      zig_c    = (cfg.zigzag && bot_r[0]) ? w1 - mir_c : mir_c;
      b_row_in = COORD_W'(bot_r);
      b_col_in = COORD_W'(zig_c);
   end

   assign c_index_in = INDEX_W'(b_row_ff) * INDEX_W'(cfg.w) + INDEX_W'(b_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= in_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) a_pix_ff <= in_pix;
      if (b_ready) begin
         b_row_ff   <= b_row_in;
         b_col_ff   <= b_col_in;
         b_color_ff <= a_pix_ff.color;
         b_last_ff  <= a_pix_ff.last;
      end
      if (c_ready) begin
         c_index_ff <= c_index_in;
         c_color_ff <= b_color_ff;
         c_last_ff  <= b_last_ff;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_index = c_index_ff;
   assign out_color = c_color_ff;
   assign out_last  = c_last_ff;

endmodule
